// ----- design/i2ctrm_pkg.sv -----
// Shared types and constants for the I2C target register map.
// No dependencies.
package i2ctrm_pkg;

    localparam int LEFT_W     = 3;
    localparam int TIME_BYTES = 4;

    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    localparam logic [7:0] TIME_SLOT = 8'hF0;
    localparam logic [1:0] SNAP_LAST = 2'(TIME_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SNAP,
        ST_RDATA,
        ST_PUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       byte_wr;
        logic       rd_start;
        logic       stop;
        logic       snap_wr;
        logic [1:0] snap_idx;
        logic       load_ram;
        logic       load_time;
        logic       push;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ptr_is_slot;
        logic out_free;
    } status_t;

endpackage

// ----- design/i2ctrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2ctrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/i2ctrm_ctrl.sv -----
// Sequencer for the I2C target register map: accepts bus events, steps reads.
// Depends on i2ctrm_pkg.
module i2ctrm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  i2ctrm_pkg::status_t status,
    output i2ctrm_pkg::cmd_t    cmd
);

    i2ctrm_pkg::state_t state_reg, state_next;
    logic [1:0]         snap_cnt_reg, snap_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= i2ctrm_pkg::ST_IDLE;
            snap_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            snap_cnt_reg <= snap_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        snap_cnt_next = snap_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        cmd.snap_idx  = snap_cnt_reg;
        unique case (state_reg)
            i2ctrm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (mode)
                        i2ctrm_pkg::MODE_RX:   cmd.byte_wr = 1'b1;
                        i2ctrm_pkg::MODE_STOP: cmd.stop    = 1'b1;
                        i2ctrm_pkg::MODE_READ:
                        begin
                            cmd.rd_start  = 1'b1;
                            snap_cnt_next = '0;
                            state_next    = status.ptr_is_slot ? i2ctrm_pkg::ST_SNAP
                                                               : i2ctrm_pkg::ST_RDATA;
                        end
                        default: ;
                    endcase
                end
            end
            i2ctrm_pkg::ST_SNAP:
            begin
                // one time byte per cycle through the single write port
                cmd.snap_wr = 1'b1;
                if (snap_cnt_reg == i2ctrm_pkg::SNAP_LAST)
                begin
                    cmd.load_time = 1'b1;
                    state_next    = i2ctrm_pkg::ST_PUSH;
                end
                else
                begin
                    snap_cnt_next = snap_cnt_reg + 2'd1;
                end
            end
            i2ctrm_pkg::ST_RDATA:
            begin
                cmd.load_ram = 1'b1;
                state_next   = i2ctrm_pkg::ST_PUSH;
            end
            i2ctrm_pkg::ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = i2ctrm_pkg::ST_IDLE;
                end
            end
            default: state_next = i2ctrm_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- design/i2ctrm_dp.sv -----
// Datapath: address counter, pointer, register store with valid bits, output beat.
// Depends on i2ctrm_pkg and i2ctrm_ram.
module i2ctrm_dp #(
    parameter int ADDRESS_BYTES = 4,
    parameter int STORE_DEPTH   = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  i2ctrm_pkg::cmd_t    cmd,
    output i2ctrm_pkg::status_t status,
    input  logic [7:0]          rx_byte,
    input  logic [31:0]         time_us,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          tx_byte
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [i2ctrm_pkg::LEFT_W-1:0] left_reg, left_next;
    logic [7:0]             ptr_reg, ptr_next;
    logic [STORE_DEPTH-1:0] vld_reg, vld_next;
    logic                   rd_vld_reg;
    logic [31:0]            time_reg;
    logic [7:0]             stage_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             tx_reg;

    logic [8:0]    snap_addr;
    logic [7:0]    snap_byte;
    logic          ptr_in_store;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    ram_rdata;

    assign ptr_in_store = {1'b0, ptr_reg} < 9'(STORE_DEPTH);
    assign snap_addr    = 9'(i2ctrm_pkg::TIME_SLOT) + 9'(cmd.snap_idx);

    always_comb
    begin
        case (cmd.snap_idx)
            2'd0:    snap_byte = time_reg[31:24];
            2'd1:    snap_byte = time_reg[23:16];
            2'd2:    snap_byte = time_reg[15:8];
            default: snap_byte = time_reg[7:0];
        endcase
    end

    // write port: data byte at pointer, or a time byte of the snapshot
    always_comb
    begin
        we      = 1'b0;
        wr_addr = ptr_reg[AW-1:0];
        wr_data = rx_byte;
        if (cmd.byte_wr && left_reg == '0 && ptr_in_store)
        begin
            we = 1'b1;
        end
        else if (cmd.snap_wr && snap_addr < 9'(STORE_DEPTH))
        begin
            we      = 1'b1;
            wr_addr = snap_addr[AW-1:0];
            wr_data = snap_byte;
        end
    end

    always_comb
    begin
        left_next = left_reg;
        ptr_next  = ptr_reg;
        vld_next  = vld_reg;
        if (we)
        begin
            vld_next[wr_addr] = 1'b1;
        end
        if (cmd.stop)
        begin
            left_next = i2ctrm_pkg::LEFT_W'(ADDRESS_BYTES);
        end
        else if (cmd.byte_wr)
        begin
            if (left_reg != '0)
            begin
                left_next = left_reg - 1'b1;
                if (left_reg == i2ctrm_pkg::LEFT_W'(1))
                begin
                    ptr_next = rx_byte;
                end
            end
            else
            begin
                ptr_next = ptr_reg + 8'd1;
            end
        end
        else if (cmd.rd_start)
        begin
            ptr_next = ptr_reg + 8'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= i2ctrm_pkg::LEFT_W'(ADDRESS_BYTES);
            ptr_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            ptr_reg       <= ptr_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_vld_reg <= vld_reg[ptr_reg[AW-1:0]] && ptr_in_store;
        if (cmd.rd_start)
        begin
            time_reg <= time_us;
        end
        if (cmd.load_ram)
        begin
            stage_reg <= rd_vld_reg ? ram_rdata : 8'h00;
        end
        else if (cmd.load_time)
        begin
            stage_reg <= (9'(i2ctrm_pkg::TIME_SLOT) < 9'(STORE_DEPTH)) ? time_reg[31:24]
                                                                       : 8'h00;
        end
        if (cmd.push)
        begin
            tx_reg <= stage_reg;
        end
    end

    i2ctrm_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign status.ptr_is_slot = ptr_reg == i2ctrm_pkg::TIME_SLOT;
    assign status.out_free    = !out_valid_reg || out_ready;
    assign out_valid          = out_valid_reg;
    assign tx_byte            = tx_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> status.out_free)
        else $error("result pushed over an undelivered beat");

    a_read_incr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_start |=> ptr_reg == 8'($past(ptr_reg) + 8'd1))
        else $error("pointer did not advance after read");

    a_stop_arm: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.stop |=> left_reg == i2ctrm_pkg::LEFT_W'(ADDRESS_BYTES))
        else $error("address collection not rearmed after stop");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(tx_reg))
        else $error("result beat changed while stalled");

endmodule

// ----- design/i2c_target_register_map.sv -----
// I2C target register map. Byte-received and stop events are taken back to back.
// A read steps through store read, staging and output load, and may stall before
// the output load while the last beat waits; a time-slot read first fills the
// four time bytes via the single store write port. tx_byte is registered. Reset
// clears pointer and per-byte valid bits, rearms address counter at once; no sweep.
module i2c_target_register_map #(
    parameter int ADDRESS_BYTES = 4,
    parameter int STORE_DEPTH   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] time_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte
);

    i2ctrm_pkg::cmd_t    cmd;
    i2ctrm_pkg::status_t status;

    i2ctrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    i2ctrm_dp #(
        .ADDRESS_BYTES (ADDRESS_BYTES),
        .STORE_DEPTH   (STORE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .rx_byte   (rx_byte),
        .time_us   (time_us),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte)
    );

endmodule
